// ===== src/lus_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lus_pkg
// Shared types and fixed widths for the largest uniform square finder.
// ----------------------------------------------------------------------------
package lus_pkg;

    // fixed port widths
    localparam int SIDE_W      = 8;
    localparam int CELL_W      = 16;
    localparam int AREA_W      = 15;
    localparam int SIDE_RESET  = 100;

    // position of a cell within the grid, travels with the cell
    typedef struct packed {
        logic row_zero;
        logic col_zero;
        logic last_cell;
    } pos_t;

endpackage : lus_pkg
`default_nettype wire

// ===== src/lus_line_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lus_line_buf
// One-row line buffer holding value and square size for each column.
// Registered read with write-to-read forwarding on the same column.
// ----------------------------------------------------------------------------
module lus_line_buf #(
    parameter int DEPTH = 128,
    parameter int VAL_W = 16,
    parameter int SZ_W  = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [VAL_W-1:0]         wr_value,
    input  wire logic [SZ_W-1:0]          wr_size,
    output logic      [VAL_W-1:0]         rd_value,
    output logic      [SZ_W-1:0]          rd_size
);

    localparam int ENT_W = VAL_W + SZ_W;

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_value, wr_size};
        end
    end

    // read port, forwarding a same-edge write to the same column
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= {wr_value, wr_size};
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_value = rd_data_reg[ENT_W-1:SZ_W];
    assign rd_size  = rd_data_reg[SZ_W-1:0];

endmodule : lus_line_buf
`default_nettype wire

// ===== src/lus_scan_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lus_scan_ctrl
// Side length register and row/column scan counters for the incoming grid.
// ----------------------------------------------------------------------------
module lus_scan_ctrl #(
    parameter int MAX_SIDE = 128
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [lus_pkg::SIDE_W-1:0]  cfg_side,
    input  wire logic                        advance,
    output logic      [$clog2(MAX_SIDE)-1:0] col,
    output lus_pkg::pos_t                    pos
);

    localparam int IDX_W  = $clog2(MAX_SIDE);
    localparam int SZ_W   = $clog2(MAX_SIDE + 1);
    localparam int SIDE_W = lus_pkg::SIDE_W;

    logic [SIDE_W-1:0] side_reg;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [SZ_W-1:0]   side_eff;
    logic [IDX_W-1:0]  side_last;
    logic              last_col, last_row;

    // clamp the side into 1..MAX_SIDE
    always_comb begin
        if (side_reg == '0) begin
            side_eff = SZ_W'(1);
        end else if (int'(side_reg) > MAX_SIDE) begin
            side_eff = SZ_W'(MAX_SIDE);
        end else begin
            side_eff = SZ_W'(side_reg);
        end
        side_last = IDX_W'(side_eff - SZ_W'(1));
    end

    assign last_col = (col_reg == side_last);
    assign last_row = (row_reg == side_last);

    // next scan position
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we) begin
            col_next = '0;
            row_next = '0;
        end else if (advance) begin
            if (!last_col) begin
                col_next = col_reg + IDX_W'(1);
            end else begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= SIDE_W'(lus_pkg::SIDE_RESET);
            col_reg  <= '0;
            row_reg  <= '0;
        end else begin
            if (cfg_we) begin
                side_reg <= cfg_side;
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col           = col_reg;
    assign pos.row_zero  = (row_reg == '0);
    assign pos.col_zero  = (col_reg == '0);
    assign pos.last_cell = last_col && last_row;

endmodule : lus_scan_ctrl
`default_nettype wire

// ===== src/largest_uniform_square_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// largest_uniform_square_top
// Streams a square grid in row-major order and reports the largest square
// of equal-valued cells as its side and area.
// ----------------------------------------------------------------------------
// Takes one cell per clock cycle, back to back, unless stalled. A cell reads
// the line buffer entry of its column on acceptance and writes its value and
// size back when it retires from the compute stage; the same column is
// forwarded when the side is one. The result of a grid is registered when
// the last cell retires. Input stalls only when a finished result is still
// waiting on m_ready and the last cell of the next grid is ready to retire.
// A write to the side length restarts the grid scan.
// ----------------------------------------------------------------------------
module largest_uniform_square_top #(
    parameter int MAX_SIDE   = 128,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // side length register
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [lus_pkg::SIDE_W-1:0]  cfg_side_length,
    // cell items
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [lus_pkg::CELL_W-1:0]  s_cell_value,
    // result items
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [lus_pkg::SIDE_W-1:0]  m_best_side,
    output logic      [lus_pkg::AREA_W-1:0]  m_best_area
);

    localparam int IDX_W  = $clog2(MAX_SIDE);
    localparam int SZ_W   = $clog2(MAX_SIDE + 1);
    localparam int VAL_W  = (VALUE_BITS < lus_pkg::CELL_W) ? VALUE_BITS : lus_pkg::CELL_W;
    localparam int SIDE_W = lus_pkg::SIDE_W;
    localparam int AREA_W = lus_pkg::AREA_W;

    logic               accept, cfg_we, stall, retire;
    logic [IDX_W-1:0]   scan_col;
    lus_pkg::pos_t      scan_pos;

    // compute stage registers
    logic               p1_valid_reg;
    logic [VAL_W-1:0]   p1_value_reg;
    logic [IDX_W-1:0]   p1_col_reg;
    lus_pkg::pos_t      p1_pos_reg;

    // neighbor and best registers
    logic [VAL_W-1:0]   left_value_reg, diag_value_reg;
    logic [SZ_W-1:0]    left_size_reg, diag_size_reg;
    logic [SZ_W-1:0]    best_reg;

    // result register
    logic               m_valid_reg;
    logic [SIDE_W-1:0]  out_side_reg;
    logic [AREA_W-1:0]  out_area_reg;
    logic [SZ_W-1:0]    out_best_reg;

    logic [VAL_W-1:0]   up_value;
    logic [SZ_W-1:0]    up_size;
    logic               match;
    logic [SZ_W-1:0]    min_size, cell_size, best_new;
    logic [2*SZ_W-1:0]  area_full;

    // handshakes
    assign stall     = p1_valid_reg && p1_pos_reg.last_cell && m_valid_reg && !m_ready;
    assign s_ready   = !stall;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign retire    = p1_valid_reg && !stall;

    lus_scan_ctrl #(
        .MAX_SIDE (MAX_SIDE)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_side (cfg_side_length),
        .advance  (accept),
        .col      (scan_col),
        .pos      (scan_pos)
    );

    lus_line_buf #(
        .DEPTH (MAX_SIDE),
        .VAL_W (VAL_W),
        .SZ_W  (SZ_W)
    ) u_line (
        .aclk     (aclk),
        .rd_en    (accept),
        .rd_addr  (scan_col),
        .wr_en    (retire),
        .wr_addr  (p1_col_reg),
        .wr_value (p1_value_reg),
        .wr_size  (cell_size),
        .rd_value (up_value),
        .rd_size  (up_size)
    );

    // accepted cell moves into the compute stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (!stall) begin
            p1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_value_reg <= s_cell_value[VAL_W-1:0];
            p1_col_reg   <= scan_col;
            p1_pos_reg   <= scan_pos;
        end
    end

    // square size at this cell
    always_comb begin
        match = !p1_pos_reg.row_zero && !p1_pos_reg.col_zero &&
                (up_value == p1_value_reg) && (left_value_reg == p1_value_reg) &&
                (diag_value_reg == p1_value_reg);
        min_size = up_size;
        if (left_size_reg < min_size) begin
            min_size = left_size_reg;
        end
        if (diag_size_reg < min_size) begin
            min_size = diag_size_reg;
        end
        cell_size = match ? min_size + SZ_W'(1) : SZ_W'(1);
        best_new  = (cell_size > best_reg) ? cell_size : best_reg;
        area_full = {{SZ_W{1'b0}}, best_new} * {{SZ_W{1'b0}}, best_new};
    end

    // neighbor and best tracking
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            left_value_reg <= '0;
            left_size_reg  <= '0;
            diag_value_reg <= '0;
            diag_size_reg  <= '0;
            best_reg       <= '0;
        end else if (retire) begin
            if (p1_pos_reg.last_cell) begin
                left_value_reg <= '0;
                left_size_reg  <= '0;
                diag_value_reg <= '0;
                diag_size_reg  <= '0;
                best_reg       <= '0;
            end else begin
                left_value_reg <= p1_value_reg;
                left_size_reg  <= cell_size;
                diag_value_reg <= up_value;
                diag_size_reg  <= up_size;
                best_reg       <= best_new;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (retire && p1_pos_reg.last_cell) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (retire && p1_pos_reg.last_cell) begin
            out_side_reg <= SIDE_W'(best_new);
            out_area_reg <= AREA_W'(area_full);
            out_best_reg <= best_new;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_best_side = out_side_reg;
    assign m_best_area = out_area_reg;

    // a grid always holds at least a one-cell square
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_best_reg != '0))
        else $error("result with zero best size");

    // first row and first column cells never extend a square
    assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && (p1_pos_reg.row_zero || p1_pos_reg.col_zero))
            |-> (cell_size == SZ_W'(1)))
        else $error("edge cell with size above one");

    // retiring the last cell presents a result and clears the best size
    assert property (@(posedge aclk) disable iff (!aresetn)
        (retire && p1_pos_reg.last_cell && !cfg_we)
            |=> (m_valid_reg && (best_reg == '0)))
        else $error("grid end did not load result");

endmodule : largest_uniform_square_top
`default_nettype wire

// ===== verif/largest_uniform_square_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_uniform_square_top_tb
// Self-checking bench for the largest uniform square finder: streams grids
// of cells through the block, predicts the best side and area of every grid
// with an in-bench line buffer model, and compares each result item with it.
// ----------------------------------------------------------------------------
module largest_uniform_square_top_tb;

    localparam int MAX_SIDE   = 128;
    localparam int VALUE_BITS = 16;
    localparam int HALF_CLK   = 6;
    localparam int DRAIN_WAIT = 4;

    typedef struct {
        logic [lus_pkg::SIDE_W-1:0] side;
        logic [lus_pkg::AREA_W-1:0] area;
    } square_result_t;

    // clock and dut ports
    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [lus_pkg::SIDE_W-1:0]  cfg_side_length;
    logic                        s_valid;
    logic                        s_ready;
    logic [lus_pkg::CELL_W-1:0]  s_cell_value;
    logic                        m_valid;
    logic                        m_ready;
    logic [lus_pkg::SIDE_W-1:0]  m_best_side;
    logic [lus_pkg::AREA_W-1:0]  m_best_area;

    // scan model state
    logic [lus_pkg::SIDE_W-1:0]  side_setting;
    logic [lus_pkg::CELL_W-1:0]  line_vals [MAX_SIDE];
    int unsigned                 line_sizes [MAX_SIDE];
    logic [lus_pkg::CELL_W-1:0]  west_val;
    int unsigned                 west_size;
    logic [lus_pkg::CELL_W-1:0]  nw_val;
    int unsigned                 nw_size;
    int unsigned                 scan_row;
    int unsigned                 scan_col;
    int unsigned                 best_size;

    square_result_t expected_squares [$];

    // run bookkeeping
    bit idle_on = 1'b0;
    int hold_cycles = 0;
    int error_count = 0;
    int cells_sent = 0;
    int squares_checked = 0;
    int side_writes = 0;

    largest_uniform_square_top #(
        .MAX_SIDE   (MAX_SIDE),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_side_length (cfg_side_length),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cell_value    (s_cell_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_best_side     (m_best_side),
        .m_best_area     (m_best_area)
    );

    // free-running clock
    always begin
        #HALF_CLK aclk = 1'b1;
        #HALF_CLK aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // scan model
    // ------------------------------------------------------------------------

    // zero acts as one, anything past the buffer depth as the full depth
    function automatic int unsigned grid_side();
        if (side_setting == 0) begin
            return 1;
        end
        if (side_setting > MAX_SIDE) begin
            return MAX_SIDE;
        end
        return int'(side_setting);
    endfunction

    function automatic void restart_scan();
        west_val  = '0;
        west_size = 0;
        nw_val    = '0;
        nw_size   = 0;
        scan_row  = 0;
        scan_col  = 0;
        best_size = 0;
    endfunction

    function automatic void set_side(input logic [lus_pkg::SIDE_W-1:0] side);
        side_setting = side;
        restart_scan();
    endfunction

    // one accepted cell: grow the square size and close the grid on its last cell
    function automatic void predict_cell(input logic [lus_pkg::CELL_W-1:0] val);
        int unsigned                side;
        int unsigned                col;
        int unsigned                up_size;
        int unsigned                size;
        int unsigned                smallest;
        int unsigned                area;
        logic [lus_pkg::CELL_W-1:0] up_val;
        square_result_t             res;
        side    = grid_side();
        col     = scan_col;
        up_val  = line_vals[col];
        up_size = line_sizes[col];
        size    = 1;
        if (scan_row > 0 && col > 0 && up_val == val && west_val == val && nw_val == val) begin
            smallest = up_size;
            if (west_size < smallest) smallest = west_size;
            if (nw_size < smallest) smallest = nw_size;
            size = smallest + 1;
        end
        // the cell above becomes the diagonal of the next column
        nw_val          = up_val;
        nw_size         = up_size;
        west_val        = val;
        west_size       = size;
        line_vals[col]  = val;
        line_sizes[col] = size;
        if (size > best_size) best_size = size;
        cells_sent++;
        if (col + 1 < side) begin
            scan_col = col + 1;
        end else begin
            scan_col = 0;
            if (scan_row + 1 < side) begin
                scan_row = scan_row + 1;
            end else begin
                area     = best_size * best_size;
                res.side = best_size[lus_pkg::SIDE_W-1:0];
                res.area = area[lus_pkg::AREA_W-1:0];
                expected_squares.push_back(res);
                restart_scan();
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        square_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_squares.size() == 0) begin
                $display("%0t: unexpected result item, side %0d area %0d",
                         $time, m_best_side, m_best_area);
                error_count++;
            end else begin
                want = expected_squares.pop_front();
                squares_checked++;
                if (m_best_side !== want.side) begin
                    $display("%0t: best_side expected %0d actual %0d",
                             $time, want.side, m_best_side);
                    error_count++;
                end
                if (m_best_area !== want.area) begin
                    $display("%0t: best_area expected %0d actual %0d",
                             $time, want.area, m_best_area);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result receiver: random stall bursts plus a long hold on request
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0) begin
                    stall_left = $urandom_range(1, 11);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // offer one cell item, with an optional idle burst in front of it
    task automatic send_cell(input logic [lus_pkg::CELL_W-1:0] val);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_cell_value <= val;
        do @(posedge aclk); while (!s_ready);
        predict_cell(val);
    endtask

    // cells drawn from a small palette, biased toward its first entry;
    // an empty palette means fully random values
    task automatic send_cells(input int count, input int pal_size, input int bias_pct);
        logic [lus_pkg::CELL_W-1:0] palette [4];
        logic [lus_pkg::CELL_W-1:0] val;
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 5))
                0: palette[i] = '0;
                1: palette[i] = '1;
                default: palette[i] = lus_pkg::CELL_W'($urandom());
            endcase
        end
        for (int i = 0; i < count; i++) begin
            if (pal_size == 0) begin
                val = lus_pkg::CELL_W'($urandom());
            end else if ($urandom_range(0, 99) < bias_pct) begin
                val = palette[0];
            end else begin
                val = palette[$urandom_range(0, pal_size - 1)];
            end
            send_cell(val);
        end
    endtask

    // let every outstanding result arrive, plus the block's pipeline depth
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_squares.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // side length write, only with the block idle
    task automatic write_side(input logic [lus_pkg::SIDE_W-1:0] side);
        wait_drained();
        @(negedge aclk);
        cfg_valid       <= 1'b1;
        cfg_side_length <= side;
        do @(posedge aclk); while (!cfg_ready);
        set_side(side);
        side_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // side length out of reset, a grid past its first row that the next write abandons
    task automatic test_reset_side();
        send_cells(lus_pkg::SIDE_RESET + 30, 1, 100);
    endtask

    // single cells, side zero, small grids with and without a full square
    task automatic test_directed();
        write_side(8'd1);
        send_cell(16'h0000);
        send_cell(16'hFFFF);
        write_side(8'd0);
        send_cell(16'h5555);
        write_side(8'd2);
        repeat (4) send_cell(16'hAAAA);
        send_cell(16'h0001);
        send_cell(16'h0002);
        send_cell(16'h0003);
        send_cell(16'h0004);
        // three by three, diagonal breaks the full square in the last cell
        write_side(8'd3);
        repeat (8) send_cell(16'h7FFF);
        send_cell(16'h8000);
    endtask

    // receiver holds off while tiny grids keep coming, so the input backs up
    task automatic test_backpressure();
        write_side(8'd2);
        hold_cycles = 400;
        for (int g = 0; g < 12; g++) begin
            send_cells(4, $urandom_range(1, 2), 70);
        end
    endtask

    // random sides and contents, back-to-back grids and aborted grids
    task automatic test_random_grids();
        int sent;
        int side;
        int reps;
        int count;
        sent = 0;
        while (sent < 300) begin
            side = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            write_side(side[lus_pkg::SIDE_W-1:0]);
            reps = $urandom_range(1, 3);
            for (int r = 0; r < reps; r++) begin
                count = side * side;
                if ($urandom_range(0, 7) == 0) begin
                    send_cells(count, 0, 0);
                end else begin
                    send_cells(count, $urandom_range(1, 4), $urandom_range(40, 95));
                end
                sent += count;
            end
            // abandon a grid part way, the next write restarts the scan
            if (side > 1 && $urandom_range(0, 5) == 0) begin
                count = $urandom_range(1, side * side - 1);
                send_cells(count, $urandom_range(1, 3), 80);
                sent += count;
            end
        end
    endtask

    // full buffer depth, and an oversized side that clamps to it, past the first row
    task automatic test_largest_grids();
        write_side(8'(MAX_SIDE));
        send_cells(MAX_SIDE + 12, 2, 98);
        write_side(8'd255);
        send_cells(MAX_SIDE + 12, 1, 100);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_side_length = '0;
        s_valid         = 1'b0;
        s_cell_value    = '0;
        for (int i = 0; i < MAX_SIDE; i++) begin
            line_vals[i]  = '0;
            line_sizes[i] = 0;
        end
        side_setting = lus_pkg::SIDE_RESET;
        restart_scan();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_side();
        idle_on = 1'b1;
        test_directed();
        test_backpressure();
        test_random_grids();
        // closing stretch runs without idling
        idle_on = 1'b0;
        test_largest_grids();

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("covered %0d cells and %0d grid results over %0d side writes,",
                 cells_sent, squares_checked, side_writes);
        $display("including sides 0 and 1, partial grids at the reset value, 128 and 255, %s",
                 "and a long output hold");
        if (error_count == 0 && expected_squares.size() == 0) begin
            $display("largest_uniform_square_top: match");
        end else begin
            $display("largest_uniform_square_top: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", expected_squares.size());
        $display("largest_uniform_square_top: mismatch");
        $finish;
    end

endmodule : largest_uniform_square_top_tb
